FILE: hw/rtl/lrfc_pkg.sv
package lrfc_pkg;

  // Ring size and derived widths
  localparam int SEGMENTS = 16;
  localparam int SEG_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int LED_W    = 16;
  localparam int PAT_W    = (SEGMENTS > LED_W) ? SEGMENTS : LED_W;

  // Field widths
  localparam int FUNC_W   = 3;
  localparam int SEGF_W   = 4;
  localparam int COUNT_W  = 8;
  localparam int TIME_W   = 4;
  localparam int ACC_W    = 8;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 24;

  // Count value that never runs out
  localparam logic [COUNT_W-1:0] ENDLESS = 8'd255;

  // Command codes (6 and 7 are no-ops)
  localparam logic [FUNC_W-1:0] FUNC_SELECT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FILL   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_START  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd5;

  // Per-segment timer word kept in the RAM
  typedef struct packed {
    logic [COUNT_W-1:0] toggles;
    logic [ACC_W-1:0]   accum;
    logic [TIME_W-1:0]  lit_time;
    logic [TIME_W-1:0]  dark_time;
  } seg_entry_t;

  localparam int ENTRY_W = $bits(seg_entry_t);

endpackage

FILE: hw/rtl/led_ring_flash_controller.sv
// Results: select/fill/set/start/stop/no-op beats give a registered result on
//   acceptance; a tick beat gives its result once its sweep has passed every segment.
// Throughput: one non-tick beat per cycle while the result side keeps up; a tick
//   holds the block while it sweeps, one segment timer per cycle through the
//   single read port of the timer RAM.
// Reset: asynchronous, active low; pattern all off, timer valid bits cleared so
//   unwritten timers read as zero; no clearing pass, ready right after reset.
module led_ring_flash_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tdata: segment[3:0], led_on[4], flash_count[12:5], on_time[16:13],
  //        off_time[20:17], start_lit[21], tick_step[29:22], zero[31:30]
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [lrfc_pkg::IN_W-1:0]   s_axis_tdata_i,
  // tuser: func[2:0]
  input  logic [lrfc_pkg::FUNC_W-1:0] s_axis_tuser_i,
  // tdata: led_pattern[15:0], any_flashing[16], zero[23:17]
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [lrfc_pkg::OUT_W-1:0]  m_axis_tdata_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  localparam int SEGMENTS = lrfc_pkg::SEGMENTS;
  localparam int SEG_W    = lrfc_pkg::SEG_W;

  // Input beat unpacking
  logic [lrfc_pkg::FUNC_W-1:0]  in_func;
  logic [lrfc_pkg::SEGF_W-1:0]  in_seg;
  logic                         in_led_on;
  logic [lrfc_pkg::COUNT_W-1:0] in_count;
  logic [lrfc_pkg::TIME_W-1:0]  in_on_time;
  logic [lrfc_pkg::TIME_W-1:0]  in_off_time;
  logic                         in_start_lit;
  logic [lrfc_pkg::ACC_W-1:0]   in_step;

  assign in_func      = s_axis_tuser_i;
  assign in_seg       = s_axis_tdata_i[3:0];
  assign in_led_on    = s_axis_tdata_i[4];
  assign in_count     = s_axis_tdata_i[12:5];
  assign in_on_time   = s_axis_tdata_i[16:13];
  assign in_off_time  = s_axis_tdata_i[20:17];
  assign in_start_lit = s_axis_tdata_i[21];
  assign in_step      = s_axis_tdata_i[29:22];

  // State
  logic                         state_q, state_d;
  logic [SEGMENTS-1:0]          pattern_q, pattern_d;
  logic [SEGMENTS-1:0]          valid_q, valid_d;
  logic [SEG_W-1:0]             idx_q, idx_d;
  logic [lrfc_pkg::ACC_W-1:0]   step_q, step_d;
  logic                         flash_q, flash_d;
  logic                         out_valid_q, out_valid_d;
  logic [lrfc_pkg::LED_W-1:0]   out_pat_q, out_pat_d;
  logic                         out_flash_q, out_flash_d;

  // Timer RAM port
  logic                         ram_we;
  logic [SEG_W-1:0]             ram_waddr;
  lrfc_pkg::seg_entry_t         ram_wdata;
  logic [SEG_W-1:0]             ram_raddr;
  logic [lrfc_pkg::ENTRY_W-1:0] ram_rdata;

  lrfc_ram #(
    .WIDTH (lrfc_pkg::ENTRY_W),
    .DEPTH (SEGMENTS)
  ) u_timer_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic in_acc;
  logic out_acc;
  logic seg_inside;
  logic last_seg;
  logic [SEG_W-1:0] seg_addr;
  logic [lrfc_pkg::PAT_W-1:0] pat_ext;

  // Tick datapath for the segment currently out of the RAM
  lrfc_pkg::seg_entry_t         cur;
  lrfc_pkg::seg_entry_t         upd;
  logic                         cur_lit;
  logic [lrfc_pkg::ACC_W-1:0]   acc_sum;
  logic [lrfc_pkg::ACC_W-1:0]   acc_lim;
  logic                         hit;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = out_valid_q && m_axis_tready_i;
  assign seg_inside      = int'(in_seg) < SEGMENTS;
  assign seg_addr        = SEG_W'(in_seg);
  assign last_seg        = idx_q == SEG_W'(SEGMENTS - 1);

  // Unwritten entries read as the reset value (all zero)
  assign cur     = valid_q[idx_q] ? lrfc_pkg::seg_entry_t'(ram_rdata) : '0;
  assign cur_lit = pattern_q[idx_q];
  assign acc_sum = lrfc_pkg::ACC_W'(cur.accum + step_q);
  assign acc_lim = cur_lit ? lrfc_pkg::ACC_W'(cur.lit_time)
                           : lrfc_pkg::ACC_W'(cur.dark_time);
  assign hit     = acc_sum >= acc_lim;

  always_comb begin
    upd          = cur;
    upd.accum    = hit ? lrfc_pkg::ACC_W'(acc_sum - acc_lim) : acc_sum;
    if (hit && (cur.toggles != lrfc_pkg::ENDLESS)) begin
      upd.toggles = lrfc_pkg::COUNT_W'(cur.toggles - 1'b1);
    end
  end

  always_comb begin
    state_d     = state_q;
    pattern_d   = pattern_q;
    valid_d     = valid_q;
    idx_d       = idx_q;
    step_d      = step_q;
    flash_d     = flash_q;
    out_valid_d = out_valid_q;
    out_pat_d   = out_pat_q;
    out_flash_d = out_flash_q;
    ram_we      = 1'b0;
    ram_waddr   = seg_addr;
    ram_wdata   = '0;
    ram_raddr   = '0;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            lrfc_pkg::FUNC_SELECT: begin
              for (int i = 0; i < SEGMENTS; i++) begin
                pattern_d[i] = int'(in_seg) == i;
              end
            end
            lrfc_pkg::FUNC_FILL: begin
              for (int i = 0; i < SEGMENTS; i++) begin
                pattern_d[i] = i <= int'(in_seg);
              end
            end
            lrfc_pkg::FUNC_SET: begin
              for (int i = 0; i < SEGMENTS; i++) begin
                if (int'(in_seg) == i) begin
                  pattern_d[i] = in_led_on;
                end
              end
            end
            lrfc_pkg::FUNC_START: begin
              if (seg_inside) begin
                ram_we              = 1'b1;
                ram_wdata.toggles   = in_count;
                ram_wdata.accum     = '0;
                ram_wdata.lit_time  = in_on_time;
                ram_wdata.dark_time = in_off_time;
                valid_d[seg_addr]   = 1'b1;
                pattern_d[seg_addr] = in_start_lit;
              end
            end
            lrfc_pkg::FUNC_STOP: begin
              // zero the whole entry; the next start rewrites it
              if (seg_inside) begin
                ram_we              = 1'b1;
                valid_d[seg_addr]   = 1'b1;
                pattern_d[seg_addr] = 1'b0;
              end
            end
            lrfc_pkg::FUNC_TICK: begin
              ram_raddr = '0;
              idx_d     = '0;
              step_d    = in_step;
              flash_d   = 1'b0;
              state_d   = ST_TICK;
            end
            default: begin
            end
          endcase

          if (in_func != lrfc_pkg::FUNC_TICK) begin
            out_valid_d = 1'b1;
            out_flash_d = 1'b0;
          end
        end
      end

      ST_TICK: begin
        // RAM data belongs to idx_q; next read goes out at idx_q + 1
        if (cur.toggles != '0) begin
          flash_d            = 1'b1;
          ram_we             = 1'b1;
          ram_waddr          = idx_q;
          ram_wdata          = upd;
          valid_d[idx_q]     = 1'b1;
          pattern_d[idx_q]   = hit ? !cur_lit : cur_lit;
        end
        if (last_seg) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_flash_d = flash_d;
        end else begin
          idx_d     = SEG_W'(idx_q + 1'b1);
          ram_raddr = idx_d;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    pat_ext = lrfc_pkg::PAT_W'(pattern_d);
    if ((state_q == ST_IDLE && in_acc && in_func != lrfc_pkg::FUNC_TICK) ||
        (state_q == ST_TICK && last_seg)) begin
      out_pat_d = pat_ext[lrfc_pkg::LED_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pattern_q   <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pattern_q   <= pattern_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    step_q      <= step_d;
    flash_q     <= flash_d;
    out_pat_q   <= out_pat_d;
    out_flash_q <= out_flash_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(lrfc_pkg::OUT_W - lrfc_pkg::LED_W - 1)'(0),
                            out_flash_q, out_pat_q};

`ifndef ASSERT_OFF
  // output register must be free while a tick sweeps, so the final result has a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TICK |-> !out_valid_q)
    else $error("output register busy during tick sweep");

  // write-back and next read never hit the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK && !last_seg && ram_we) |-> ram_raddr != ram_waddr)
    else $error("timer RAM read/write collision");

  // sweep index stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TICK |-> int'(idx_q) < SEGMENTS)
    else $error("tick index out of range");

  // only a tick can report flashing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_func != lrfc_pkg::FUNC_TICK) |=> (out_valid_q && !out_flash_q))
    else $error("non-tick beat reported flashing");

  // the sweep's last segment registers a result and the return to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK && last_seg) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("tick sweep did not deliver a result");
`endif

endmodule

FILE: hw/rtl/lrfc_ram.sv
module lrfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: verif/led_ring_flash_controller_test.sv
module led_ring_flash_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Shared sizes and codes
  localparam int SEGMENTS = lrfc_pkg::SEGMENTS;
  localparam int LED_W    = lrfc_pkg::LED_W;
  localparam int FUNC_W   = lrfc_pkg::FUNC_W;
  localparam int SEGF_W   = lrfc_pkg::SEGF_W;
  localparam int COUNT_W  = lrfc_pkg::COUNT_W;
  localparam int TIME_W   = lrfc_pkg::TIME_W;
  localparam int ACC_W    = lrfc_pkg::ACC_W;
  localparam int IN_W     = lrfc_pkg::IN_W;
  localparam int OUT_W    = lrfc_pkg::OUT_W;

  localparam logic [COUNT_W-1:0] ENDLESS = lrfc_pkg::ENDLESS;

  localparam logic [FUNC_W-1:0] FUNC_SELECT = lrfc_pkg::FUNC_SELECT;
  localparam logic [FUNC_W-1:0] FUNC_FILL   = lrfc_pkg::FUNC_FILL;
  localparam logic [FUNC_W-1:0] FUNC_SET    = lrfc_pkg::FUNC_SET;
  localparam logic [FUNC_W-1:0] FUNC_START  = lrfc_pkg::FUNC_START;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = lrfc_pkg::FUNC_STOP;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = lrfc_pkg::FUNC_TICK;
  // Spare codes, no-ops in the block
  localparam logic [FUNC_W-1:0] FUNC_SPARE0 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE1 = 3'd7;

  // Input beat layout, lowest bit up (tuser carries func)
  localparam int SEG_LSB   = 0;
  localparam int LED_LSB   = 4;
  localparam int COUNT_LSB = 5;
  localparam int ON_LSB    = 13;
  localparam int OFF_LSB   = 17;
  localparam int START_LSB = 21;
  localparam int STEP_LSB  = 22;

  // Base idle rate per side, percent of cycles
  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_BEATS = 1600;
  // Settle time at the end covers a tick sweep with margin for stray beats
  localparam int SETTLE_CYCLES = 2 * SEGMENTS + 4;

  typedef struct packed {
    logic [LED_W-1:0] leds;
    logic             flashing;
  } ring_result_t;

  // Predicts the LED ring and holds the results still owed by the block
  class ring_scoreboard;
    logic [LED_W-1:0]   leds;
    logic [COUNT_W-1:0] flash_left [SEGMENTS];
    logic [ACC_W-1:0]   timer      [SEGMENTS];
    logic [TIME_W-1:0]  lit_ticks  [SEGMENTS];
    logic [TIME_W-1:0]  dark_ticks [SEGMENTS];
    ring_result_t       owed_results [$];
    int                 errors;

    function new();
      leds   = '0;
      errors = 0;
      for (int j = 0; j < SEGMENTS; j++) begin
        flash_left[j] = '0;
        timer[j]      = '0;
        lit_ticks[j]  = '0;
        dark_ticks[j] = '0;
      end
    endfunction

    // One tick over all segment timers; returns whether any was flashing
    function logic advance_timers(logic [ACC_W-1:0] step);
      logic             busy;
      logic             lit;
      logic [ACC_W-1:0] limit;
      busy = 1'b0;
      for (int j = 0; j < SEGMENTS; j++) begin
        if (flash_left[j] != '0) begin
          busy     = 1'b1;
          timer[j] = timer[j] + step;
          lit      = leds[j];
          limit    = lit ? ACC_W'(lit_ticks[j]) : ACC_W'(dark_ticks[j]);
          if (timer[j] >= limit) begin
            timer[j] = timer[j] - limit;
            leds[j]  = !lit;
            if (flash_left[j] != ENDLESS) flash_left[j] = flash_left[j] - 1'b1;
          end
        end
      end
      return busy;
    endfunction

    function void note_command(logic [FUNC_W-1:0] func, logic [IN_W-1:0] beat);
      logic [SEGF_W-1:0] seg;
      logic [LED_W:0]    span;
      ring_result_t      res;
      seg          = beat[SEG_LSB +: SEGF_W];
      res.flashing = 1'b0;
      case (func)
        FUNC_SELECT: begin
          leds = '0;
          if (seg < SEGMENTS) leds[seg] = 1'b1;
        end
        FUNC_FILL: begin
          span = ((LED_W+1)'(1) << (seg + 1)) - 1'b1;
          leds = span[LED_W-1:0];
        end
        FUNC_SET: begin
          if (seg < SEGMENTS) leds[seg] = beat[LED_LSB];
        end
        FUNC_START: begin
          if (seg < SEGMENTS) begin
            flash_left[seg] = beat[COUNT_LSB +: COUNT_W];
            timer[seg]      = '0;
            lit_ticks[seg]  = beat[ON_LSB +: TIME_W];
            dark_ticks[seg] = beat[OFF_LSB +: TIME_W];
            leds[seg]       = beat[START_LSB];
          end
        end
        FUNC_STOP: begin
          if (seg < SEGMENTS) begin
            flash_left[seg] = '0;
            leds[seg]       = 1'b0;
          end
        end
        FUNC_TICK: begin
          res.flashing = advance_timers(beat[STEP_LSB +: ACC_W]);
        end
        default: ;
      endcase
      res.leds = leds;
      owed_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_W-1:0] beat);
      ring_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, beat);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (beat[LED_W-1:0] !== want.leds) begin
        $display("%0t: led_pattern expected %h actual %h", $realtime, want.leds,
                 beat[LED_W-1:0]);
        errors++;
      end
      if (beat[LED_W] !== want.flashing) begin
        $display("%0t: any_flashing expected %b actual %b", $realtime, want.flashing,
                 beat[LED_W]);
        errors++;
      end
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // tdata: segment, led_on, flash_count, on_time, off_time, start_lit, tick_step, zero
  logic [IN_W-1:0]     s_axis_tdata_i  = '0;
  // tuser: func
  logic [FUNC_W-1:0]   s_axis_tuser_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // tdata: led_pattern, any_flashing, zero
  logic [OUT_W-1:0]    m_axis_tdata_o;

  ring_scoreboard board = new();
  int             idle_pct = IDLE_PCT;

  led_ring_flash_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side: random backpressure, changed on the falling edge only
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= idle_pct);
  end

  // Result beats are checked at the rising edge they are taken on. DUT outputs
  // update in the NBA region, so the values read here are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_result(m_axis_tdata_o);
    end
  end

  function automatic logic [IN_W-1:0] pack_command(
    logic [SEGF_W-1:0] seg, logic led_on, logic [COUNT_W-1:0] count,
    logic [TIME_W-1:0] on_t, logic [TIME_W-1:0] off_t, logic start_lit,
    logic [ACC_W-1:0] step);
    return {2'b00, step, start_lit, off_t, on_t, count, led_on, seg};
  endfunction

  // Present one command beat, with random idle cycles ahead of it. Valid only
  // gets one assignment per falling edge, so back-to-back beats stay high.
  task automatic send_command(input logic [FUNC_W-1:0] func, input logic [IN_W-1:0] beat);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= beat;
    s_axis_tuser_i  <= func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_command(func, beat);
  endtask

  // Stop sending and hold off until every owed result is back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (board.owed() != 0) @(posedge clk_i);
  endtask

  // One random command. Mostly starts and ticks, often with small counts and steps so that
  // flashes actually run out; the rest is arbitrary content.
  task automatic send_random_command();
    logic [IN_W-1:0]   beat;
    logic [FUNC_W-1:0] func;
    int                pick;
    beat = {2'b00, 30'($urandom())};
    pick = $urandom_range(99);
    if (pick < 38) func = FUNC_TICK;
    else if (pick < 60) func = FUNC_START;
    else if (pick < 70) func = FUNC_STOP;
    else if (pick < 80) func = FUNC_SET;
    else if (pick < 87) func = FUNC_SELECT;
    else if (pick < 94) func = FUNC_FILL;
    else func = ($urandom_range(1) == 0) ? FUNC_SPARE0 : FUNC_SPARE1;
    if (func == FUNC_START) begin
      case ($urandom_range(3))
        0: beat[COUNT_LSB +: COUNT_W] = COUNT_W'($urandom_range(1, 6));
        1: beat[COUNT_LSB +: COUNT_W] = ENDLESS;
        2: beat[COUNT_LSB +: COUNT_W] = COUNT_W'($urandom_range(0, 2));
        default: ;
      endcase
    end
    if (func == FUNC_TICK && $urandom_range(1) == 0) begin
      beat[STEP_LSB +: ACC_W] = ACC_W'($urandom_range(0, 8));
    end
    send_command(func, beat);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every command, zero times, endless and empty
    // flashes, spare func codes
    send_command(FUNC_SELECT, pack_command(4'd0, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd0));
    send_command(FUNC_SELECT, pack_command(4'd15, 1'b1, 8'hff, 4'hf, 4'hf, 1'b1, 8'hff));
    send_command(FUNC_FILL, pack_command(4'd0, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd0));
    send_command(FUNC_FILL, pack_command(4'd15, 1'b1, 8'hff, 4'hf, 4'hf, 1'b1, 8'hff));
    send_command(FUNC_SET, pack_command(4'd3, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd0));
    send_command(FUNC_SET, pack_command(4'd3, 1'b1, 8'd0, 4'd0, 4'd0, 1'b0, 8'd0));
    send_command(FUNC_TICK, pack_command(4'd0, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd1));
    send_command(FUNC_START, pack_command(4'd0, 1'b0, ENDLESS, 4'd0, 4'd0, 1'b1, 8'd0));
    send_command(FUNC_TICK, pack_command(4'd0, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd0));
    send_command(FUNC_TICK, pack_command(4'd0, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd0));
    send_command(FUNC_START, pack_command(4'd15, 1'b1, ENDLESS, 4'hf, 4'hf, 1'b1, 8'hff));
    send_command(FUNC_START, pack_command(4'd7, 1'b0, 8'd3, 4'd2, 4'd1, 1'b0, 8'd0));
    send_command(FUNC_START, pack_command(4'd5, 1'b1, 8'd0, 4'd1, 4'd1, 1'b1, 8'd0));
    send_command(FUNC_TICK, pack_command(4'd0, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd1));
    send_command(FUNC_TICK, pack_command(4'hf, 1'b1, 8'hff, 4'hf, 4'hf, 1'b1, 8'hff));
    send_command(FUNC_TICK, pack_command(4'd0, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd1));
    send_command(FUNC_TICK, pack_command(4'd0, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd14));
    send_command(FUNC_STOP, pack_command(4'd0, 1'b1, 8'hff, 4'hf, 4'hf, 1'b1, 8'hff));
    send_command(FUNC_STOP, pack_command(4'd15, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd0));
    send_command(FUNC_SPARE0, pack_command(4'd9, 1'b1, 8'hff, 4'hf, 4'hf, 1'b1, 8'hff));
    send_command(FUNC_SPARE1, pack_command(4'd2, 1'b1, 8'hff, 4'hf, 4'hf, 1'b1, 8'hff));
    send_command(FUNC_TICK, pack_command(4'd0, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'hff));
    send_command(FUNC_FILL, pack_command(4'd7, 1'b0, 8'd0, 4'd0, 4'd0, 1'b0, 8'd0));

    // Random part, with a stretch of full-rate traffic on both sides and two
    // points where the sender waits for the block to empty
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 500 || n == 1200) drain_results();
      idle_pct = (n >= 700 && n < 1000) ? 0 : IDLE_PCT;
      send_random_command();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #15ms;
    $display("simulation failed");
    $finish;
  end

endmodule
